@@ hw/rtl/pqadc_pkg.sv @@
package pqadc_pkg;

    typedef enum logic [1:0] {
        OP_CB_WRITE = 2'd0,
        OP_Q_WRITE  = 2'd1,
        OP_BUILD    = 2'd2,
        OP_CODE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUILD = 2'd1,
        ST_EMIT  = 2'd2
    } state_t;

    localparam int VALUE_W = 16;
    localparam int TAG_W   = 32;
    localparam int ENTRY_W = 35;
    localparam int DIST_W  = 39;
    localparam int SQ_W    = 34;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        op_t                op;
        logic [3:0]         sub_index;
        logic [7:0]         centroid;
        logic [6:0]         component;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [TAG_W-1:0]   tag;
    } req_t;

endpackage

@@ hw/rtl/pq_adc_distance.sv @@
// Channel | Dir | Payload (lowest bit first)
// s_axis  | in  | tdata: op, sub_index, centroid, component, value, tag; tuser: -; tlast: last
// m_axis  | out | tdata: tag_res, distance; tuser: kind, rejected
// cfg     | in  | data: reject_threshold
// A code or write request is issued, then its table read or store write
// settles during a gap; a code's sum lands in the cycle after issue.
// A build request walks every codebook word once, one per cycle, and then
// waits for its four-stage pipeline to drain.
// rst_n clears control state asynchronously; the stores hold no reset value.
// A full output register stalls the back end; the two-entry queue lets input
// requests keep arriving meanwhile.
module pq_adc_distance
#(
    parameter int DIM           = 128,
    parameter int SUBSPACES     = 16,
    parameter int CENTROID_BITS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // op, sub_index, centroid, component, value, tag
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // tag_res, distance, zero pad
    output logic [1:0]   m_axis_tuser,   // kind, rejected
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [38:0]  cfg_data
);

    pqadc_pkg::req_t in_req, q_req;
    logic q_valid, q_ready, code_gap_reg, back_ready;
    logic [pqadc_pkg::DIST_W-1:0] thr_reg;
    logic kind, rej;
    logic [31:0] tag_res;
    logic [38:0] distance;

    assign in_req.op        = pqadc_pkg::op_t'(s_axis_tdata[1:0]);
    assign in_req.sub_index = s_axis_tdata[5:2];
    assign in_req.centroid  = s_axis_tdata[13:6];
    assign in_req.component = s_axis_tdata[20:14];
    assign in_req.value     = s_axis_tdata[36:21];
    assign in_req.tag       = s_axis_tdata[68:37];
    assign in_req.last      = s_axis_tlast;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // Every accepted request is followed by a gap cycle, so a code's table
    // read and sum settle before the next request or a result handover.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_gap_reg <= 1'b0;
        else
            code_gap_reg <= q_valid && q_ready;
    end

    assign q_ready = back_ready && !code_gap_reg && !m_axis_tvalid;

    pqadc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (in_req),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_req   (q_req)
    );

    pqadc_back #(
        .DIM           (DIM),
        .SUBSPACES     (SUBSPACES),
        .CENTROID_BITS (CENTROID_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (q_valid && !code_gap_reg && !m_axis_tvalid),
        .req_ready (back_ready),
        .req       (q_req),
        .threshold (thr_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_kind  (kind),
        .res_tag   (tag_res),
        .res_dist  (distance),
        .res_rej   (rej)
    );

    assign m_axis_tdata = {1'b0, distance, tag_res};
    assign m_axis_tuser = {rej, kind};

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        code_gap_reg |-> !q_ready) else $error("request taken in gap cycle");
    a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !q_ready) else $error("request taken while result waits");
    a_tuser_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[71] == 1'b0)) else $error("pad bit set");

endmodule

@@ hw/rtl/pqadc_front.sv @@
module pqadc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pqadc_pkg::req_t   in_req,
    output logic              out_valid,
    input  logic              out_ready,
    output pqadc_pkg::req_t   out_req
);

    // Two-entry queue between the input port and the back end.
    pqadc_pkg::req_t q_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_req;
    end

    q_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count overflow");
    q_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
    q_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");

endmodule

@@ hw/rtl/pqadc_back.sv @@
module pqadc_back
#(
    parameter int DIM           = 128,
    parameter int SUBSPACES     = 16,
    parameter int CENTROID_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  pqadc_pkg::req_t               req,
    input  logic [pqadc_pkg::DIST_W-1:0]  threshold,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          res_kind,
    output logic [pqadc_pkg::TAG_W-1:0]   res_tag,
    output logic [pqadc_pkg::DIST_W-1:0]  res_dist,
    output logic                          res_rej
);

    localparam int SUBDIM  = DIM / SUBSPACES;
    localparam int NCENT   = 1 << CENTROID_BITS;
    localparam int SW      = (SUBSPACES > 1) ? $clog2(SUBSPACES) : 1;
    localparam int DW      = (SUBDIM > 1) ? $clog2(SUBDIM) : 1;
    localparam int QW      = $clog2(DIM);
    localparam int TB_AW   = SW + CENTROID_BITS;
    localparam int CB_DEPTH = SUBSPACES * NCENT * SUBDIM;
    localparam int TB_DEPTH = SUBSPACES * NCENT;
    localparam int VW      = pqadc_pkg::VALUE_W;
    localparam int EW      = pqadc_pkg::ENTRY_W;
    localparam int DSW     = pqadc_pkg::DIST_W;
    localparam int SQW     = pqadc_pkg::SQ_W;

    logic [VW-1:0] cb_mem [CB_DEPTH];
    logic [VW-1:0] q_mem  [DIM];
    logic [EW-1:0] tb_mem [TB_DEPTH];

    pqadc_pkg::state_t state_reg, state_next;

    // Build walk counters: subspace, centroid, dimension.
    logic [SW-1:0]            bm_reg, bm_next;
    logic [CENTROID_BITS-1:0] bc_reg, bc_next;
    logic [DW-1:0]            bd_reg, bd_next;
    logic                     walk_reg, walk_next;

    // Pipeline: read stage, difference stage, square stage, accumulate.
    logic                p1_v_reg, p1_last_reg;
    logic [TB_AW-1:0]    p1_a_reg;
    logic [VW-1:0]       rq_reg, rw_reg;
    logic                p2_v_reg, p2_last_reg;
    logic [TB_AW-1:0]    p2_a_reg;
    logic signed [VW:0]  diff_reg;
    logic                p3_v_reg, p3_last_reg;
    logic [TB_AW-1:0]    p3_a_reg;
    logic [SQW-1:0]      sq_reg;
    logic [EW-1:0]       acc_reg;
    logic                bdone_reg;

    logic [DSW-1:0]      sum_reg;
    logic                o_v_reg, o_kind_reg, o_rej_reg;
    logic [pqadc_pkg::TAG_W-1:0] o_tag_reg;
    logic [DSW-1:0]      o_dist_reg;

    logic take, sub_ok, out_free, walk_end;
    logic [DSW-1:0] code_sum;
    logic [EW-1:0]  acc_new;
    logic [VW-1:0]   diff_mag;
    logic [2*VW-1:0] diff_sq;

    assign out_free  = !o_v_reg || res_ready;
    assign req_ready = (state_reg == pqadc_pkg::ST_IDLE) && out_free;
    assign take      = req_valid && req_ready;
    assign sub_ok    = ({28'd0, req.sub_index} < 32'(SUBSPACES));
    assign walk_end  = (bd_reg == DW'(SUBDIM - 1)) && (bc_reg == CENTROID_BITS'(NCENT - 1))
                     && (bm_reg == SW'(SUBSPACES - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pqadc_pkg::ST_IDLE:
                if (take && req.op == pqadc_pkg::OP_BUILD)
                    state_next = pqadc_pkg::ST_BUILD;
            pqadc_pkg::ST_BUILD:
                if (bdone_reg)
                    state_next = pqadc_pkg::ST_EMIT;
            pqadc_pkg::ST_EMIT:
                if (out_free)
                    state_next = pqadc_pkg::ST_IDLE;
            default:
                state_next = pqadc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        walk_next = walk_reg;
        bm_next = bm_reg;
        bc_next = bc_reg;
        bd_next = bd_reg;
        unique case (state_reg)
            pqadc_pkg::ST_IDLE:
                if (take && req.op == pqadc_pkg::OP_BUILD)
                begin
                    walk_next = 1'b1;
                    bm_next = '0;
                    bc_next = '0;
                    bd_next = '0;
                end
            pqadc_pkg::ST_BUILD:
                if (walk_reg)
                begin
                    if (walk_end)
                        walk_next = 1'b0;
                    if (bd_reg == DW'(SUBDIM - 1))
                    begin
                        bd_next = '0;
                        bc_next = bc_reg + 1'b1;
                        if (bc_reg == CENTROID_BITS'(NCENT - 1))
                            bm_next = bm_reg + 1'b1;
                    end
                    else
                        bd_next = bd_reg + 1'b1;
                end
            default:
                walk_next = walk_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pqadc_pkg::ST_IDLE;
            walk_reg  <= 1'b0;
            bm_reg    <= '0;
            bc_reg    <= '0;
            bd_reg    <= '0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            bdone_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            bm_reg    <= bm_next;
            bc_reg    <= bc_next;
            bd_reg    <= bd_next;
            p1_v_reg  <= walk_reg;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            bdone_reg <= p3_v_reg && p3_last_reg && (p3_a_reg == TB_AW'(TB_DEPTH - 1));
        end
    end

    assign acc_new = acc_reg + EW'(sq_reg);

    // The square is taken of the magnitude, which always fits in VW bits.
    assign diff_mag = diff_reg[VW] ? VW'(-diff_reg) : VW'(diff_reg);
    assign diff_sq  = diff_mag * diff_mag;

    // Memory read stage and arithmetic datapath.
    always_ff @(posedge clk)
    begin
        rq_reg      <= q_mem[QW'(bm_reg) * QW'(SUBDIM) + QW'(bd_reg)];
        rw_reg      <= cb_mem[{bm_reg, bc_reg, bd_reg}];
        p1_a_reg    <= {bm_reg, bc_reg};
        p1_last_reg <= (bd_reg == DW'(SUBDIM - 1));
        diff_reg    <= $signed({rq_reg[VW-1], rq_reg}) - $signed({rw_reg[VW-1], rw_reg});
        p2_a_reg    <= p1_a_reg;
        p2_last_reg <= p1_last_reg;
        sq_reg      <= SQW'(diff_sq);
        p3_a_reg    <= p2_a_reg;
        p3_last_reg <= p2_last_reg;
        // The accumulator starts from zero for the first entry of every build.
        if (take && req.op == pqadc_pkg::OP_BUILD)
            acc_reg <= '0;
        if (p3_v_reg)
        begin
            acc_reg <= p3_last_reg ? '0 : acc_new;
            if (p3_last_reg)
                tb_mem[p3_a_reg] <= acc_new;
        end
        if (take && req.op == pqadc_pkg::OP_CB_WRITE && sub_ok
            && ({25'd0, req.component} < 32'(SUBDIM)))
            cb_mem[{SW'(req.sub_index), req.centroid[CENTROID_BITS-1:0],
                    DW'(req.component)}] <= req.value;
        if (take && req.op == pqadc_pkg::OP_Q_WRITE && ({25'd0, req.component} < 32'(DIM)))
            q_mem[QW'(req.component)] <= req.value;
    end

    // Code items: the table read is registered and lands in the next cycle, so
    // the top level inserts a gap after each taken request before the next one.
    logic            cv_reg, clast_reg, cok_reg;
    logic [pqadc_pkg::TAG_W-1:0] ctag_reg;
    logic [EW-1:0]   tq_reg;

    always_ff @(posedge clk)
    begin
        tq_reg    <= tb_mem[{SW'(req.sub_index), req.centroid[CENTROID_BITS-1:0]}];
        clast_reg <= req.last;
        cok_reg   <= sub_ok;
        ctag_reg  <= req.tag;
    end

    assign code_sum = sum_reg + (cok_reg ? DSW'(tq_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg  <= 1'b0;
            sum_reg <= '0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            cv_reg <= take && req.op == pqadc_pkg::OP_CODE;
            if (o_v_reg && res_ready)
                o_v_reg <= 1'b0;
            if (cv_reg)
            begin
                sum_reg <= clast_reg ? '0 : code_sum;
                if (clast_reg)
                    o_v_reg <= 1'b1;
            end
            if (state_reg == pqadc_pkg::ST_EMIT && out_free)
                o_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cv_reg && clast_reg)
        begin
            o_kind_reg <= 1'b1;
            o_tag_reg  <= ctag_reg;
            o_dist_reg <= code_sum;
            o_rej_reg  <= (threshold != '0) && (code_sum > threshold);
        end
        else if (state_reg == pqadc_pkg::ST_EMIT && out_free)
        begin
            o_kind_reg <= 1'b0;
            o_tag_reg  <= '0;
            o_dist_reg <= '0;
            o_rej_reg  <= 1'b0;
        end
    end

    assign res_valid = o_v_reg;
    assign res_kind  = o_kind_reg;
    assign res_tag   = o_tag_reg;
    assign res_dist  = o_dist_reg;
    assign res_rej   = o_rej_reg;

    // A result could otherwise be overwritten by a code landing after its take.
    // So the front must not hand over while a code is in flight and the
    // output is full; the top's gap after each take and out_free cover that.
    a_build_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pqadc_pkg::ST_BUILD) |-> !req_ready) else $error("take during build");
    a_walk_only_build: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg |-> (state_reg == pqadc_pkg::ST_BUILD)) else $error("walk outside build");
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && !o_kind_reg) |-> !o_rej_reg) else $error("reject on table result");

endmodule
